// File: sv/value_lifetime_tracker_defines.svh
// Assertion macros shared by the value lifetime tracker checker.
// Needs clk and rst_n in the scope where a macro is used.
`ifndef VALUE_LIFETIME_TRACKER_DEFINES_SVH
`define VALUE_LIFETIME_TRACKER_DEFINES_SVH

// same-cycle implication, disabled during reset
`define VLT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define VLT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/vlt_pkg.sv
// Shared types and constants of the value lifetime tracker.
// No dependencies; used by the controller, datapath and top level.
package vlt_pkg;

  localparam int unsigned MAX_VALUES_DEF = 32;
  localparam int unsigned STEP_BITS_DEF  = 16;

  localparam int unsigned ID_W     = 5;   // value id field
  localparam int unsigned IO_STEP_W = 16; // step fields at the ports
  localparam int unsigned USE_W    = 16;  // saturating use counter
  localparam int unsigned MCNT_W   = 2;   // materialize counter, saturates at 2

  localparam logic [IO_STEP_W-1:0] STEP_COUNT_RST = 16'hFFFF;
  localparam logic [USE_W-1:0]     USE_SAT        = 16'hFFFF;
  localparam logic [MCNT_W-1:0]    MCNT_ONE       = 2'd1;
  localparam logic [MCNT_W-1:0]    MCNT_SAT       = 2'd2;

  localparam logic REQ_EVENT  = 1'b0;
  localparam logic REQ_FINISH = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UPD,   // write back the updated entry
    ST_CRD,   // check sweep: read entry
    ST_CDAT,  // check sweep: inspect entry
    ST_ERD,   // emit sweep: read entry
    ST_EDAT,  // emit sweep: send lifetime word
    ST_STAT   // send closing status word, clear table
  } vlt_state_t;

  typedef struct packed {
    logic ev_read;    // read entry at incoming id, capture event
    logic ev_write;   // write back updated entry
    logic set_abort;
    logic cnt_clr;
    logic cnt_inc;
    logic cnt_read;   // read entry at sweep counter
    logic plan_init;
    logic chk_apply;
    logic load_life;
    logic load_stat;
    logic tbl_clear;
  } vlt_cmd_t;

  typedef struct packed {
    logic aborted;
    logic step_oob;
    logic id_oob;
    logic entry_bad;
    logic entry_used;
    logic cnt_last;
    logic out_free;
  } vlt_sts_t;

endpackage

// File: sv/vlt_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module vlt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: sv/vlt_ctrl.sv
// Controller of the value lifetime tracker: event update, check and emit sweeps.
// Depends on vlt_pkg; drives the datapath by vlt_cmd_t, reads vlt_sts_t.
module vlt_ctrl import vlt_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     in_req_type,
  output logic     in_ready,
  input  vlt_sts_t sts,
  output vlt_cmd_t cmd
);

  vlt_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    in_ready  = (state_r == ST_IDLE);
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_req_type == REQ_FINISH) begin
            cmd.cnt_clr   = 1'b1;
            cmd.plan_init = 1'b1;
            state_nxt     = sts.aborted ? ST_STAT : ST_CRD;
          end else if (!sts.aborted) begin
            if (sts.step_oob) begin
              cmd.set_abort = 1'b1;
            end else if (!sts.id_oob) begin
              cmd.ev_read = 1'b1;
              state_nxt   = ST_UPD;
            end
          end
        end
      end
      ST_UPD: begin
        cmd.ev_write = 1'b1;
        state_nxt    = ST_IDLE;
      end
      ST_CRD: begin
        cmd.cnt_read = 1'b1;
        state_nxt    = ST_CDAT;
      end
      ST_CDAT: begin
        cmd.chk_apply = 1'b1;
        if (sts.entry_bad) begin
          state_nxt = ST_STAT;
        end else if (sts.cnt_last) begin
          cmd.cnt_clr = 1'b1;
          state_nxt   = ST_ERD;
        end else begin
          cmd.cnt_inc = 1'b1;
          state_nxt   = ST_CRD;
        end
      end
      ST_ERD: begin
        cmd.cnt_read = 1'b1;
        state_nxt    = ST_EDAT;
      end
      ST_EDAT: begin
        // unused entries are skipped without waiting on the output
        if (!sts.entry_used || sts.out_free) begin
          cmd.load_life = sts.entry_used;
          if (sts.cnt_last) begin
            state_nxt = ST_STAT;
          end else begin
            cmd.cnt_inc = 1'b1;
            state_nxt   = ST_ERD;
          end
        end
      end
      ST_STAT: begin
        if (sts.out_free) begin
          cmd.load_stat = 1'b1;
          cmd.tbl_clear = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

// File: sv/vlt_dpath.sv
// Datapath of the value lifetime tracker: entry table, update and check logic,
// sweep counter, limit register and output register. Depends on vlt_pkg, vlt_ram.
module vlt_dpath import vlt_pkg::*; #(
  parameter int unsigned MAX_VALUES = MAX_VALUES_DEF,
  parameter int unsigned STEP_BITS  = STEP_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  vlt_cmd_t             cmd,
  output vlt_sts_t             sts,
  input  logic [ID_W-1:0]      in_value_id,
  input  logic [IO_STEP_W-1:0] in_event_step,
  input  logic                 in_is_materialize,
  input  logic                 cfg_we,
  input  logic [IO_STEP_W-1:0] cfg_step_count,
  input  logic                 out_ready,
  output logic                 out_valid,
  output logic                 out_entry_valid,
  output logic [ID_W-1:0]      out_value_id,
  output logic [IO_STEP_W-1:0] out_first_live,
  output logic [IO_STEP_W-1:0] out_last_live,
  output logic [USE_W-1:0]     out_uses,
  output logic                 out_was_materialized,
  output logic                 out_plan_valid,
  output logic                 out_last
);

  localparam int unsigned IDX_W   = $clog2(MAX_VALUES);
  localparam int unsigned SW      = STEP_BITS;
  localparam int unsigned ENTRY_W = 3 * SW + MCNT_W + USE_W;
  localparam logic [IO_STEP_W-1:0] STEP_MASK = (STEP_BITS >= IO_STEP_W) ? 16'hFFFF :
                                               16'((32'd1 << STEP_BITS) - 32'd1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_VALUES - 1);

  // limit register and abort flag
  logic [IO_STEP_W-1:0] step_count_r;
  logic                 aborted_r;
  logic [IO_STEP_W-1:0] step_in;

  assign step_in = in_event_step & STEP_MASK;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_count_r <= STEP_COUNT_RST;
    end else if (cfg_we) begin
      step_count_r <= cfg_step_count;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      aborted_r <= 1'b0;
    end else if (cmd.tbl_clear) begin
      aborted_r <= 1'b0;
    end else if (cmd.set_abort) begin
      aborted_r <= 1'b1;
    end
  end

  // captured event
  logic [SW-1:0]    ev_step_r;
  logic             ev_mat_r;
  logic [IDX_W-1:0] ev_id_r;

  always_ff @(posedge clk) begin
    if (cmd.ev_read) begin
      ev_step_r <= SW'(step_in);
      ev_mat_r  <= in_is_materialize;
      ev_id_r   <= IDX_W'(in_value_id);
    end
  end

  // sweep counter
  logic [IDX_W-1:0] cnt_r;

  always_ff @(posedge clk) begin
    if (cmd.cnt_clr) begin
      cnt_r <= '0;
    end else if (cmd.cnt_inc) begin
      cnt_r <= cnt_r + IDX_W'(1);
    end
  end

  // entry table; a slot without its valid bit reads as all zero
  logic [MAX_VALUES-1:0] vld_r;
  logic                  vld_q_r;
  logic [IDX_W-1:0]      rd_addr;
  logic                  rd_en;
  logic [ENTRY_W-1:0]    rd_word;
  logic [ENTRY_W-1:0]    ent;
  logic [ENTRY_W-1:0]    wr_word;

  assign rd_en   = cmd.ev_read | cmd.cnt_read;
  assign rd_addr = cmd.ev_read ? IDX_W'(in_value_id) : cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (cmd.tbl_clear) begin
      vld_r <= '0;
    end else if (cmd.ev_write) begin
      vld_r[ev_id_r] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      vld_q_r <= vld_r[rd_addr];
    end
  end

  vlt_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_VALUES)
  ) u_tbl (
    .clk   (clk),
    .we    (cmd.ev_write),
    .waddr (ev_id_r),
    .wdata (wr_word),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd_word)
  );

  assign ent = vld_q_r ? rd_word : '0;

  logic [SW-1:0]     e_mat_step, e_first_use, e_last_use;
  logic [MCNT_W-1:0] e_mcnt;
  logic [USE_W-1:0]  e_ucnt;

  assign {e_mat_step, e_first_use, e_last_use, e_mcnt, e_ucnt} = ent;

  // read-modify-write of one entry
  logic [SW-1:0]     n_mat_step, n_first_use, n_last_use;
  logic [MCNT_W-1:0] n_mcnt;
  logic [USE_W-1:0]  n_ucnt;

  always_comb begin
    n_mat_step  = e_mat_step;
    n_first_use = e_first_use;
    n_last_use  = e_last_use;
    n_mcnt      = e_mcnt;
    n_ucnt      = e_ucnt;
    if (ev_mat_r) begin
      if (e_mcnt == '0 || ev_step_r < e_mat_step) begin
        n_mat_step = ev_step_r;
      end
      if (e_mcnt < MCNT_SAT) begin
        n_mcnt = e_mcnt + MCNT_W'(1);
      end
    end else begin
      if (e_ucnt == '0) begin
        n_first_use = ev_step_r;
        n_last_use  = ev_step_r;
      end else begin
        if (ev_step_r < e_first_use) begin
          n_first_use = ev_step_r;
        end
        if (ev_step_r > e_last_use) begin
          n_last_use = ev_step_r;
        end
      end
      if (e_ucnt != USE_SAT) begin
        n_ucnt = e_ucnt + USE_W'(1);
      end
    end
  end

  assign wr_word = {n_mat_step, n_first_use, n_last_use, n_mcnt, n_ucnt};

  // plan check
  logic plan_ok_r;
  logic e_bad;
  logic e_single_mat;

  assign e_single_mat = (e_mcnt == MCNT_ONE);
  assign e_bad = (e_mcnt >= MCNT_SAT) ||
                 (e_single_mat && e_ucnt != '0 && e_mat_step > e_first_use);

  always_ff @(posedge clk) begin
    if (cmd.plan_init) begin
      plan_ok_r <= !aborted_r;
    end else if (cmd.chk_apply && e_bad) begin
      plan_ok_r <= 1'b0;
    end
  end

  // output register
  logic out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_life || cmd.load_stat) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_life) begin
      out_entry_valid      <= 1'b1;
      out_value_id         <= ID_W'(cnt_r);
      out_first_live       <= IO_STEP_W'(e_single_mat ? e_mat_step : e_first_use);
      out_last_live        <= IO_STEP_W'(e_last_use);
      out_uses             <= e_ucnt;
      out_was_materialized <= e_single_mat;
      out_plan_valid       <= 1'b0;
      out_last             <= 1'b0;
    end else if (cmd.load_stat) begin
      out_entry_valid      <= 1'b0;
      out_value_id         <= '0;
      out_first_live       <= '0;
      out_last_live        <= '0;
      out_uses             <= '0;
      out_was_materialized <= 1'b0;
      out_plan_valid       <= plan_ok_r;
      out_last             <= 1'b1;
    end
  end

  assign out_valid = out_valid_r;

  // status to the controller
  always_comb begin
    sts            = '0;
    sts.aborted    = aborted_r;
    sts.step_oob   = (step_in >= step_count_r);
    sts.id_oob     = ({1'b0, in_value_id} >= 6'(MAX_VALUES));
    sts.entry_bad  = e_bad;
    sts.entry_used = (e_ucnt != '0);
    sts.cnt_last   = (cnt_r == LAST_IDX);
    sts.out_free   = !out_valid_r || out_ready;
  end

endmodule

// File: sv/value_lifetime_tracker.sv
// Top level of the value lifetime tracker.
// Depends on vlt_pkg, vlt_ctrl, vlt_dpath (and vlt_ram below it).
//
// Collects materialize/use events per value id into a MAX_VALUES-entry table
// and on a finish word reports, when the plan is valid, one lifetime per used
// value, ascending id, then a status word with last set. An event that is
// dropped or that aborts the plan is handled in the idle state alone; an
// event that updates the table passes a table read, then a write-back,
// since the table is a single RAM with registered read. A finish is taken
// in the idle state, then the check sweep reads and inspects each entry (ended
// early by a bad entry, skipped if the plan was aborted), then, when the plan
// is valid, the emit sweep reads each entry again, then the status word is
// sent; output back-pressure can stall the emit sweep and the status word.
// The table is emptied at once after each finish, no clearing pass.
// cfg_ready is always high; write cfg_step_count only while idle.
module value_lifetime_tracker import vlt_pkg::*; #(
  parameter int unsigned MAX_VALUES = MAX_VALUES_DEF,
  parameter int unsigned STEP_BITS  = STEP_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [IO_STEP_W-1:0] cfg_step_count,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_req_type,
  input  logic [ID_W-1:0]      in_value_id,
  input  logic [IO_STEP_W-1:0] in_event_step,
  input  logic                 in_is_materialize,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 out_entry_valid,
  output logic [ID_W-1:0]      out_value_id,
  output logic [IO_STEP_W-1:0] out_first_live,
  output logic [IO_STEP_W-1:0] out_last_live,
  output logic [USE_W-1:0]     out_uses,
  output logic                 out_was_materialized,
  output logic                 out_plan_valid,
  output logic                 out_last
);

  vlt_cmd_t cmd;
  vlt_sts_t sts;

  assign cfg_ready = 1'b1;

  vlt_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_req_type (in_req_type),
    .in_ready    (in_ready),
    .sts         (sts),
    .cmd         (cmd)
  );

  vlt_dpath #(
    .MAX_VALUES (MAX_VALUES),
    .STEP_BITS  (STEP_BITS)
  ) u_dpath (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .sts                  (sts),
    .in_value_id          (in_value_id),
    .in_event_step        (in_event_step),
    .in_is_materialize    (in_is_materialize),
    .cfg_we               (cfg_valid & cfg_ready),
    .cfg_step_count       (cfg_step_count),
    .out_ready            (out_ready),
    .out_valid            (out_valid),
    .out_entry_valid      (out_entry_valid),
    .out_value_id         (out_value_id),
    .out_first_live       (out_first_live),
    .out_last_live        (out_last_live),
    .out_uses             (out_uses),
    .out_was_materialized (out_was_materialized),
    .out_plan_valid       (out_plan_valid),
    .out_last             (out_last)
  );

endmodule

// File: sv/vlt_checker.sv
// Port-level checks of the value lifetime tracker, bound to the top level.
// Depends on vlt_pkg and value_lifetime_tracker_defines.svh.
`include "value_lifetime_tracker_defines.svh"

module vlt_checker import vlt_pkg::*; (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_ready,
  input logic                 in_req_type,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic                 out_entry_valid,
  input logic [ID_W-1:0]      out_value_id,
  input logic [IO_STEP_W-1:0] out_first_live,
  input logic [IO_STEP_W-1:0] out_last_live,
  input logic [USE_W-1:0]     out_uses,
  input logic                 out_was_materialized,
  input logic                 out_plan_valid,
  input logic                 out_last
);

  // a stalled result word holds
  `VLT_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
    out_valid && $stable(out_entry_valid) && $stable(out_value_id) &&
    $stable(out_first_live) && $stable(out_last_live) && $stable(out_uses) &&
    $stable(out_plan_valid) && $stable(out_last), "stalled result word changed")

  // the status word closes the run and carries no lifetime
  `VLT_ASSERT_NOW(a_stat_shape, out_valid && !out_entry_valid,
    out_last && out_value_id == '0 && out_first_live == '0 && out_last_live == '0 &&
    out_uses == '0 && !out_was_materialized, "malformed status word")

  // a lifetime word reports a used value and never ends the run
  `VLT_ASSERT_NOW(a_life_shape, out_valid && out_entry_valid,
    !out_last && !out_plan_valid && out_uses != '0, "malformed lifetime word")

  // lifetimes are only sent while the finish run still owns the block
  `VLT_ASSERT_NOW(a_life_busy, out_valid && out_entry_valid,
    !in_ready, "input taken while a lifetime word is pending")

  // a finish word makes the block busy
  `VLT_ASSERT_NEXT(a_finish_busy, in_valid && in_ready && in_req_type == REQ_FINISH,
    !in_ready, "ready right after a finish word")

endmodule

bind value_lifetime_tracker vlt_checker u_vlt_checker (.*);

// File: sim/value_lifetime_tracker_tb.sv
// Self-checking testbench for value_lifetime_tracker: directed table, then random plans.
// Needs vlt_pkg and the tracker RTL; keeps its own lifetime predictor and scoreboard.
`timescale 1ns / 1ps

module value_lifetime_tracker_tb;
  import vlt_pkg::*;

  localparam logic EV_MAT = 1'b1;
  localparam logic EV_USE = 1'b0;
  localparam int NVAL = MAX_VALUES_DEF;
  localparam int HOLD_CYCLES = 2000;
  localparam int SETTLE_CYCLES = 8;

  typedef struct packed {
    logic                 req;
    logic [ID_W-1:0]      id;
    logic [IO_STEP_W-1:0] step;
    logic                 mat;
  } plan_ev_t;

  // typed = expected word written in the row: one status word with plan_valid = pv
  typedef struct packed {
    plan_ev_t ev;
    logic     typed;
    logic     pv;
  } dir_row_t;

  typedef struct packed {
    logic                 entry_valid;
    logic [ID_W-1:0]      id;
    logic [IO_STEP_W-1:0] first_step;
    logic [IO_STEP_W-1:0] last_live;
    logic [USE_W-1:0]     uses;
    logic                 was_mat;
    logic                 plan_valid;
    logic                 last;
  } life_word_t;

  localparam int DIR_ROWS = 23;
  localparam dir_row_t DIR_TAB [0:DIR_ROWS-1] = '{
    '{'{REQ_FINISH, 5'd0,  16'd0,     EV_USE}, 1'b1, 1'b1},  // empty table after reset
    '{'{REQ_EVENT,  5'd0,  16'd0,     EV_MAT}, 1'b0, 1'b0},
    '{'{REQ_EVENT,  5'd0,  16'd0,     EV_USE}, 1'b0, 1'b0},
    '{'{REQ_EVENT,  5'd31, 16'd65534, EV_USE}, 1'b0, 1'b0},
    '{'{REQ_EVENT,  5'd31, 16'd100,   EV_USE}, 1'b0, 1'b0},
    '{'{REQ_EVENT,  5'd5,  16'd7,     EV_USE}, 1'b0, 1'b0},
    '{'{REQ_EVENT,  5'd6,  16'd2,     EV_MAT}, 1'b0, 1'b0},  // materialized, never used
    '{'{REQ_EVENT,  5'd7,  16'd300,   EV_MAT}, 1'b0, 1'b0},
    '{'{REQ_EVENT,  5'd7,  16'd300,   EV_USE}, 1'b0, 1'b0},  // use on the materialize step
    '{'{REQ_FINISH, 5'd0,  16'd0,     EV_USE}, 1'b0, 1'b0},
    '{'{REQ_EVENT,  5'd3,  16'd65535, EV_USE}, 1'b0, 1'b0},  // step out of range: abort
    '{'{REQ_EVENT,  5'd1,  16'd3,     EV_MAT}, 1'b0, 1'b0},  // dropped after abort
    '{'{REQ_FINISH, 5'd31, 16'd65535, EV_MAT}, 1'b1, 1'b0},
    '{'{REQ_EVENT,  5'd2,  16'd10,    EV_MAT}, 1'b0, 1'b0},
    '{'{REQ_EVENT,  5'd2,  16'd4,     EV_MAT}, 1'b0, 1'b0},  // second materialize
    '{'{REQ_FINISH, 5'd0,  16'd0,     EV_USE}, 1'b1, 1'b0},
    '{'{REQ_EVENT,  5'd3,  16'd5,     EV_USE}, 1'b0, 1'b0},
    '{'{REQ_EVENT,  5'd3,  16'd6,     EV_MAT}, 1'b0, 1'b0},  // materialized after first use
    '{'{REQ_FINISH, 5'd0,  16'd0,     EV_USE}, 1'b1, 1'b0},
    '{'{REQ_FINISH, 5'd31, 16'd65535, EV_MAT}, 1'b1, 1'b1},
    '{'{REQ_EVENT,  5'd8,  16'd65534, EV_MAT}, 1'b0, 1'b0},
    '{'{REQ_EVENT,  5'd8,  16'd65534, EV_USE}, 1'b0, 1'b0},
    '{'{REQ_FINISH, 5'd0,  16'd0,     EV_USE}, 1'b0, 1'b0}
  };

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [IO_STEP_W-1:0] cfg_step_count = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic                 in_req_type = REQ_EVENT;
  logic [ID_W-1:0]      in_value_id = '0;
  logic [IO_STEP_W-1:0] in_event_step = '0;
  logic                 in_is_materialize = EV_USE;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic                 out_entry_valid;
  logic [ID_W-1:0]      out_value_id;
  logic [IO_STEP_W-1:0] out_first_live;
  logic [IO_STEP_W-1:0] out_last_live;
  logic [USE_W-1:0]     out_uses;
  logic                 out_was_materialized;
  logic                 out_plan_valid;
  logic                 out_last;

  value_lifetime_tracker u_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_step_count      (cfg_step_count),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_req_type         (in_req_type),
    .in_value_id         (in_value_id),
    .in_event_step       (in_event_step),
    .in_is_materialize   (in_is_materialize),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_entry_valid     (out_entry_valid),
    .out_value_id        (out_value_id),
    .out_first_live      (out_first_live),
    .out_last_live       (out_last_live),
    .out_uses            (out_uses),
    .out_was_materialized(out_was_materialized),
    .out_plan_valid      (out_plan_valid),
    .out_last            (out_last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state
  logic [IO_STEP_W-1:0] lt_step_count;
  logic [IO_STEP_W-1:0] lt_mat_step [NVAL];
  logic [IO_STEP_W-1:0] lt_first_use [NVAL];
  logic [IO_STEP_W-1:0] lt_last_use [NVAL];
  logic [MCNT_W-1:0]    lt_mat_cnt [NVAL];
  logic [USE_W-1:0]     lt_use_cnt [NVAL];
  bit                   lt_aborted;

  life_word_t exp_words [$];    // words still owed by the block
  life_word_t fresh_words [$];  // words predicted for the word just taken
  life_word_t want_word;
  int errors = 0;
  int words_sent = 0;
  int tx_gap_max = 12;
  int rx_gap_max = 12;
  int rx_wait = 0;
  bit hold_req = 1'b0;

  task automatic clear_lifetimes();
    for (int i = 0; i < NVAL; i++) begin
      lt_mat_step[i] = '0;
      lt_first_use[i] = '0;
      lt_last_use[i] = '0;
      lt_mat_cnt[i] = '0;
      lt_use_cnt[i] = '0;
    end
    lt_aborted = 1'b0;
  endtask

  task automatic predict_lifetimes(input logic req, input logic [ID_W-1:0] id,
                                   input logic [IO_STEP_W-1:0] step, input logic mat);
    bit ok;
    life_word_t w;
    if (req == REQ_EVENT) begin
      if (!lt_aborted) begin
        if (step >= lt_step_count) begin
          lt_aborted = 1'b1;
        end else if (mat == EV_MAT) begin
          if (lt_mat_cnt[id] == '0 || step < lt_mat_step[id]) lt_mat_step[id] = step;
          if (lt_mat_cnt[id] < MCNT_SAT) lt_mat_cnt[id] = lt_mat_cnt[id] + 1'b1;
        end else begin
          if (lt_use_cnt[id] == '0) begin
            lt_first_use[id] = step;
            lt_last_use[id] = step;
          end else begin
            if (step < lt_first_use[id]) lt_first_use[id] = step;
            if (step > lt_last_use[id]) lt_last_use[id] = step;
          end
          if (lt_use_cnt[id] != USE_SAT) lt_use_cnt[id] = lt_use_cnt[id] + 1'b1;
        end
      end
    end else begin
      ok = !lt_aborted;
      for (int i = 0; i < NVAL; i++) begin
        if (lt_mat_cnt[i] >= MCNT_SAT) ok = 1'b0;
        else if (lt_mat_cnt[i] == MCNT_ONE && lt_use_cnt[i] != '0 &&
                 lt_mat_step[i] > lt_first_use[i]) ok = 1'b0;
      end
      if (ok) begin
        for (int i = 0; i < NVAL; i++) begin
          if (lt_use_cnt[i] != '0) begin
            w = '0;
            w.entry_valid = 1'b1;
            w.id = ID_W'(i);
            w.was_mat = (lt_mat_cnt[i] == MCNT_ONE);
            w.first_step = w.was_mat ? lt_mat_step[i] : lt_first_use[i];
            w.last_live = lt_last_use[i];
            w.uses = lt_use_cnt[i];
            fresh_words.insert(fresh_words.size(), w);
          end
        end
      end
      w = '0;
      w.plan_valid = ok;
      w.last = 1'b1;
      fresh_words.insert(fresh_words.size(), w);
      clear_lifetimes();
    end
  endtask

  // Offer one word, wait for it to be taken, then book what it should produce.
  task automatic send_word(input logic req, input logic [ID_W-1:0] id,
                           input logic [IO_STEP_W-1:0] step, input logic mat,
                           input bit typed = 1'b0, input bit pv = 1'b0);
    int gap;
    life_word_t w;
    gap = $urandom_range(tx_gap_max, 0);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req_type <= req;
    in_value_id <= id;
    in_event_step <= step;
    in_is_materialize <= mat;
    do @(posedge clk); while (!(in_valid && in_ready));
    words_sent++;
    predict_lifetimes(req, id, step, mat);
    if (typed) begin
      fresh_words.delete();
      w = '0;
      w.plan_valid = pv;
      w.last = 1'b1;
      exp_words.insert(exp_words.size(), w);
    end else begin
      foreach (fresh_words[k]) exp_words.insert(exp_words.size(), fresh_words[k]);
      fresh_words.delete();
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (exp_words.size() != 0) @(posedge clk);
    // an event word still in write-back leaves no trace in the queue
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_step_count(input logic [IO_STEP_W-1:0] val);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_step_count <= val;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    lt_step_count = val;
    cfg_valid <= 1'b0;
  endtask

  // One plan: events for a set of value ids, or random noise words, in random order, then a finish.
  task automatic run_plan(input bit all_ids);
    plan_ev_t ev_q [$];
    plan_ev_t ev;
    int id_pool [NVAL];
    int kind, sub, nvals, hi, m, u, j, tmp;
    plan_ev_t swp;
    kind = $urandom_range(9, 0);
    nvals = (all_ids || $urandom_range(9, 0) == 0) ? NVAL : $urandom_range(6, 1);
    hi = int'(lt_step_count) - 1;
    tx_gap_max = ($urandom_range(3, 0) == 0) ? 0 : 12;
    for (int i = 0; i < NVAL; i++) id_pool[i] = i;
    for (int i = NVAL - 1; i > 0; i--) begin
      j = $urandom_range(i, 0);
      tmp = id_pool[i];
      id_pool[i] = id_pool[j];
      id_pool[j] = tmp;
    end
    if (kind == 9 && !all_ids) begin
      // noise: any field, an odd finish among them
      repeat ($urandom_range(10, 3)) begin
        ev.req = ($urandom_range(7, 0) == 0) ? REQ_FINISH : REQ_EVENT;
        ev.id = 5'($urandom);
        ev.step = 16'($urandom);
        ev.mat = 1'($urandom);
        ev_q.insert(ev_q.size(), ev);
      end
    end else begin
      for (int i = 0; i < nvals; i++) begin
        ev.req = REQ_EVENT;
        ev.id = 5'(id_pool[i]);
        if (hi < 0) begin
          ev.step = 16'($urandom);
          ev.mat = 1'($urandom);
          ev_q.insert(ev_q.size(), ev);
        end else begin
          m = 0;
          if ($urandom_range(2, 0) != 0) begin
            m = $urandom_range(hi, 0);
            ev.step = 16'(m);
            ev.mat = EV_MAT;
            ev_q.insert(ev_q.size(), ev);
          end
          repeat ($urandom_range(3, 0)) begin
            ev.step = 16'($urandom_range(hi, m));
            ev.mat = EV_USE;
            ev_q.insert(ev_q.size(), ev);
          end
        end
      end
      if (kind >= 7 && hi >= 0 && !all_ids) begin
        ev.req = REQ_EVENT;
        ev.id = 5'(id_pool[0]);
        sub = $urandom_range(2, 0);
        if (sub == 2) begin
          ev.step = 16'($urandom_range(65535, int'(lt_step_count)));
          ev.mat = 1'($urandom);
          ev_q.insert(ev_q.size(), ev);
        end else if (sub == 1 && hi > 0) begin
          u = $urandom_range(hi - 1, 0);
          ev.step = 16'(u);
          ev.mat = EV_USE;
          ev_q.insert(ev_q.size(), ev);
          ev.step = 16'($urandom_range(hi, u + 1));
          ev.mat = EV_MAT;
          ev_q.insert(ev_q.size(), ev);
        end else begin
          repeat (2) begin
            ev.step = 16'($urandom_range(hi, 0));
            ev.mat = EV_MAT;
            ev_q.insert(ev_q.size(), ev);
          end
        end
      end
    end
    for (int i = ev_q.size() - 1; i > 0; i--) begin
      j = $urandom_range(i, 0);
      swp = ev_q[i];
      ev_q[i] = ev_q[j];
      ev_q[j] = swp;
    end
    for (int i = 0; i < ev_q.size(); i++)
      send_word(ev_q[i].req, ev_q[i].id, ev_q[i].step, ev_q[i].mat);
    send_word(REQ_FINISH, 5'($urandom), 16'($urandom), 1'($urandom));
  endtask

  // receiver: random wait per word, runs of no waiting, one long hold on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      rx_wait = 0;
    end else begin
      if (hold_req) begin
        rx_wait = HOLD_CYCLES;
        hold_req = 1'b0;
      end else if (out_valid && out_ready) begin
        if ($urandom_range(19, 0) == 0) rx_gap_max = (rx_gap_max == 0) ? 12 : 0;
        rx_wait = $urandom_range(rx_gap_max, 0);
      end
      if (rx_wait != 0) begin
        out_ready <= 1'b0;
        rx_wait--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t ns: %s expected %0d got %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (exp_words.size() == 0) begin
        errors++;
        $display("%0t ns: word expected none, got id %0d entry_valid %0b last %0b",
                 $time, out_value_id, out_entry_valid, out_last);
      end else begin
        want_word = exp_words[0];
        exp_words.delete(0);
        check_field("entry_valid", 16'(want_word.entry_valid), 16'(out_entry_valid));
        check_field("out id", 16'(want_word.id), 16'(out_value_id));
        check_field("first_step", want_word.first_step, out_first_live);
        check_field("last_live", want_word.last_live, out_last_live);
        check_field("uses", want_word.uses, out_uses);
        check_field("was_materialized", 16'(want_word.was_mat), 16'(out_was_materialized));
        check_field("plan_valid", 16'(want_word.plan_valid), 16'(out_plan_valid));
        check_field("last", 16'(want_word.last), 16'(out_last));
      end
    end
  end

  initial begin
    #20_000_000;
    $display("FAIL value_lifetime_tracker");
    $finish;
  end

  initial begin
    logic [IO_STEP_W-1:0] phase_sc [5];
    int phase_len [5];
    int target;
    lt_step_count = STEP_COUNT_RST;
    clear_lifetimes();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    write_step_count(16'hFFFF);
    for (int r = 0; r < DIR_ROWS; r++)
      send_word(DIR_TAB[r].ev.req, DIR_TAB[r].ev.id, DIR_TAB[r].ev.step,
                DIR_TAB[r].ev.mat, DIR_TAB[r].typed, DIR_TAB[r].pv);

    phase_sc[0] = 16'd0;
    phase_sc[1] = 16'd1;
    phase_sc[2] = 16'($urandom_range(300, 2));
    phase_sc[3] = 16'($urandom_range(65534, 301));
    phase_sc[4] = 16'hFFFF;
    phase_len[0] = 20;
    phase_len[1] = 40;
    phase_len[2] = 50;
    phase_len[3] = 60;
    phase_len[4] = 40;
    for (int p = 0; p < 5; p++) begin
      write_step_count(phase_sc[p]);
      target = words_sent + phase_len[p];
      if (p == 4) begin
        // stall the output while a full table drains and more words queue up
        hold_req = 1'b1;
        run_plan(1'b1);
        run_plan(1'b0);
      end
      while (words_sent < target) run_plan(1'b0);
    end

    wait_drained();
    if (errors == 0 && exp_words.size() == 0) begin
      $display("PASS value_lifetime_tracker");
    end else begin
      $display("FAIL value_lifetime_tracker");
    end
    $finish;
  end

endmodule
